// ===== rtl/brtr_pkg.sv =====
// Shared types, constants and codes of the byte ring buffer with token read.
package brtr_pkg;

	localparam int BYTE_W = 8;
	localparam int CAP_W  = 11;
	localparam int CNT_W  = 11;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 7;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;

	localparam int STORE_DEPTH_DEF = 1024;
	localparam int MAX_RUN_DEF     = 64;
	localparam int CAP_RESET       = 1024;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_TOKEN  = 2'd3
	} brtr_mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_REJECT = 2'd1,
		STAT_NODATA = 2'd2
	} brtr_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIX,
		ST_DIV,
		ST_RUN
	} brtr_state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] data_byte;
		logic [CNT_W-1:0]  count;
		logic [BYTE_W-1:0] token_byte;
		logic [IDX_W-1:0]  peek_index;
		logic              discard;
	} brtr_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic [POS_W-1:0]  byte_position;
		logic              last;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  fill_level;
	} brtr_out_t;

	typedef struct packed {
		logic take;
		logic fix;
		logic div_step;
		logic emit;
	} brtr_cmd_t;

	typedef struct packed {
		logic out_free;
		logic imm;
		logic peek;
		logic fix_big;
		logic div_done;
		logic run_last;
	} brtr_stat_t;

endpackage

// ===== rtl/brtr_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface brtr_in_if;
	logic               valid;
	logic               ready;
	brtr_pkg::brtr_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface brtr_out_if;
	logic                valid;
	logic                ready;
	brtr_pkg::brtr_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/brtr_ctrl.sv =====
// Controller state machine that sequences item intake, peek index folding and read runs.
module brtr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  brtr_pkg::brtr_stat_t   stat,
	output brtr_pkg::brtr_cmd_t    cmd
);
	import brtr_pkg::*;

	brtr_state_t state_q;
	brtr_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					cmd.take = 1'b1;
					if (!stat.imm) begin
						state_nx = stat.peek ? ST_FIX : ST_RUN;
					end
				end
			end
			ST_FIX: begin
				cmd.fix  = 1'b1;
				state_nx = stat.fix_big ? ST_DIV : ST_RUN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_nx = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.run_last) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/brtr_dp.sv =====
// Datapath: byte store, pointers, append run state, peek remainder unit and result queue.
module brtr_dp #(
	parameter int STORE_DEPTH = brtr_pkg::STORE_DEPTH_DEF,
	parameter int MAX_RUN     = brtr_pkg::MAX_RUN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [brtr_pkg::CAP_W-1:0]  cfg_wdata,
	input  brtr_pkg::brtr_in_t          in_data,
	input  brtr_pkg::brtr_cmd_t         cmd,
	output brtr_pkg::brtr_stat_t        stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output brtr_pkg::brtr_out_t         out_data
);
	import brtr_pkg::*;

	localparam int AW       = $clog2(STORE_DEPTH);
	localparam int XW       = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam int DIV_CW   = $clog2(IDX_W + 1);
	localparam int CAP_INIT = (CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : CAP_RESET;

	// Byte store: one write port for appends, one registered read port for runs.
	logic [BYTE_W-1:0] mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	// Buffer state.
	logic [CAP_W-1:0] cap_q;
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] app_rem_q;
	logic             app_rej_q;

	// Item held during a run.
	logic [MODE_W-1:0] mode_q;
	logic [POS_W-1:0]  n_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] tok_q;
	logic [IDX_W-1:0]  fix_a_q;
	logic [AW-1:0]     addr_q;
	logic [IDX_W-1:0]  dvd_q;
	logic [IDX_W-1:0]  rem_q;
	logic [DIV_CW-1:0] div_cnt_q;

	// Result queue of two entries.
	logic [1:0] ofill_q;
	brtr_out_t  e0_q;
	brtr_out_t  e1_q;

	// Capacity as written, brought into range.
	logic [XW-1:0]    cfg_x;
	logic [CAP_W-1:0] cap_nx;

	// Intake decode.
	logic [POS_W-1:0] n_sat;
	logic [POS_W-1:0] n_rm;
	logic [CNT_W-1:0] len;
	logic             app_first;
	logic             app_rej;
	logic [CNT_W-1:0] app_rem_nx;
	logic             app_drop;
	logic [XW-1:0]    wp_x;
	logic [AW-1:0]    wp_inc;
	logic [XW-1:0]    disc_x;
	logic             imm;
	logic             is_peek;
	brtr_out_t        imm_res;

	// Run side.
	logic [XW-1:0]    inc_x;
	logic [AW-1:0]    inc_addr;
	logic [POS_W-1:0] pos_nx;
	logic             pop;
	logic [CNT_W-1:0] cnt_run;
	logic             hit;
	logic             run_last;
	brtr_out_t        run_res;

	// Peek index folding.
	logic [IDX_W-1:0] a1;
	logic             fix_big;
	logic [XW-1:0]    a1_x;
	logic [IDX_W:0]   trial;
	logic [IDX_W-1:0] rem_nx;
	logic [XW-1:0]    rem_x;
	logic             div_done;

	// Read port and queue control.
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          push;
	logic          pop_o;
	brtr_out_t     res;

	always_comb begin
		cfg_x = XW'(cfg_wdata);
		if (cfg_wdata == '0) begin
			cap_nx = CAP_W'(1);
		end else if (cfg_x > XW'(STORE_DEPTH)) begin
			cap_nx = CAP_W'(STORE_DEPTH);
		end else begin
			cap_nx = cfg_wdata;
		end
	end

	always_comb begin
		n_sat = (in_data.count > CNT_W'(MAX_RUN)) ? POS_W'(MAX_RUN)
			: in_data.count[POS_W-1:0];
		n_rm  = (CNT_W'(n_sat) > cnt_q) ? cnt_q[POS_W-1:0] : n_sat;

		len        = (in_data.count == '0) ? CNT_W'(1) : in_data.count;
		app_first  = (app_rem_q == '0);
		app_rej    = app_first ? (len > (cap_q - cnt_q)) : app_rej_q;
		app_rem_nx = (app_first ? len : app_rem_q) - CNT_W'(1);
		app_drop   = app_rej || (cnt_q >= CNT_W'(cap_q));

		wp_x   = XW'(wp_q) + XW'(1);
		wp_inc = (wp_x >= XW'(cap_q)) ? '0 : wp_x[AW-1:0];

		disc_x = XW'(rp_q) + XW'(n_rm);
		if (disc_x >= XW'(cap_q)) begin
			disc_x = disc_x - XW'(cap_q);
		end

		is_peek = (in_data.mode == MODE_PEEK);

		imm_res.read_byte     = '0;
		imm_res.byte_position = '0;
		imm_res.last          = 1'b1;
		imm_res.status        = (cnt_q == '0) ? STAT_NODATA : STAT_OK;
		imm_res.fill_level    = cnt_q;
		case (in_data.mode)
			MODE_APPEND: begin
				imm                = 1'b1;
				imm_res.status     = app_drop ? STAT_REJECT : STAT_OK;
				imm_res.fill_level = app_drop ? cnt_q : cnt_q + CNT_W'(1);
			end
			MODE_REMOVE: begin
				imm = (n_rm == '0) || in_data.discard;
				if (n_rm != '0) begin
					imm_res.byte_position = n_rm;
					imm_res.status        = STAT_OK;
					imm_res.fill_level    = cnt_q - CNT_W'(n_rm);
				end
			end
			MODE_PEEK: begin
				imm            = (n_sat == '0);
				imm_res.status = STAT_OK;
			end
			MODE_TOKEN: begin
				imm = (n_sat == '0) || (cnt_q == '0);
			end
			default: begin
				imm = 1'b1;
			end
		endcase
	end

	always_comb begin
		inc_x    = XW'(addr_q) + XW'(1);
		inc_addr = (inc_x >= XW'(cap_q)) ? '0 : inc_x[AW-1:0];
		pos_nx   = pos_q + POS_W'(1);
		pop      = (mode_q != MODE_PEEK);
		cnt_run  = pop ? cnt_q - CNT_W'(1) : cnt_q;
		hit      = (mode_q == MODE_TOKEN) && (rdata_q == tok_q);
		run_last = (pos_nx == n_q) || (pop && (hit || (cnt_run == '0)));

		run_res.read_byte     = rdata_q;
		run_res.byte_position = pos_nx;
		run_res.last          = run_last;
		run_res.status        = STAT_OK;
		run_res.fill_level    = cnt_run;
	end

	// The peek index is reduced once by the capacity; if it is still too large
	// the restoring remainder unit finishes the job one bit per cycle.
	always_comb begin
		a1       = (fix_a_q >= IDX_W'(cap_q)) ? fix_a_q - IDX_W'(cap_q) : fix_a_q;
		fix_big  = (a1 >= IDX_W'(cap_q));
		a1_x     = XW'(a1);
		trial    = {rem_q, dvd_q[IDX_W-1]};
		rem_nx   = (trial >= (IDX_W+1)'(cap_q)) ? IDX_W'(trial - (IDX_W+1)'(cap_q))
			: trial[IDX_W-1:0];
		rem_x    = XW'(rem_nx);
		div_done = (div_cnt_q == DIV_CW'(IDX_W - 1));
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rp_q;
		if (cmd.take && !imm && !is_peek) begin
			rd_en   = 1'b1;
			rd_addr = rp_q;
		end else if (cmd.fix && !fix_big) begin
			rd_en   = 1'b1;
			rd_addr = a1_x[AW-1:0];
		end else if (cmd.div_step && div_done) begin
			rd_en   = 1'b1;
			rd_addr = rem_x[AW-1:0];
		end else if (cmd.emit && !run_last) begin
			rd_en   = 1'b1;
			rd_addr = inc_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (in_data.mode == MODE_APPEND) && !app_drop) begin
			mem[wp_q] <= in_data.data_byte;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_W'(CAP_INIT);
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
			app_rem_q <= '0;
			app_rej_q <= 1'b0;
		end else if (cfg_we) begin
			cap_q     <= cap_nx;
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
			app_rem_q <= '0;
			app_rej_q <= 1'b0;
		end else if (cmd.take) begin
			if (in_data.mode == MODE_APPEND) begin
				app_rem_q <= app_rem_nx;
				app_rej_q <= (app_rem_nx == '0) ? 1'b0 : app_rej;
				if (!app_drop) begin
					wp_q  <= wp_inc;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if ((in_data.mode == MODE_REMOVE) && in_data.discard && (n_rm != '0)) begin
				rp_q  <= disc_x[AW-1:0];
				cnt_q <= cnt_q - CNT_W'(n_rm);
			end
		end else if (cmd.emit && pop) begin
			rp_q  <= inc_addr;
			cnt_q <= cnt_run;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !imm) begin
			mode_q  <= in_data.mode;
			n_q     <= (in_data.mode == MODE_REMOVE) ? n_rm : n_sat;
			tok_q   <= in_data.token_byte;
			pos_q   <= '0;
			fix_a_q <= in_data.peek_index;
		end else if (cmd.emit) begin
			pos_q <= pos_nx;
		end
		if (rd_en) begin
			addr_q <= rd_addr;
		end
		if (cmd.fix) begin
			dvd_q     <= a1;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q     <= {dvd_q[IDX_W-2:0], 1'b0};
			rem_q     <= rem_nx;
			div_cnt_q <= div_cnt_q + DIV_CW'(1);
		end
	end

	assign push  = (cmd.take && imm) || cmd.emit;
	assign res   = cmd.emit ? run_res : imm_res;
	assign pop_o = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofill_q <= '0;
		end else begin
			case ({push, pop_o})
				2'b10:   ofill_q <= ofill_q + 2'd1;
				2'b01:   ofill_q <= ofill_q - 2'd1;
				default: ofill_q <= ofill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && ((ofill_q == 2'd0) || ((ofill_q == 2'd1) && pop_o))) begin
			e0_q <= res;
		end else if (pop_o && (ofill_q == 2'd2)) begin
			e0_q <= e1_q;
		end
		if (push && (ofill_q == 2'd1) && !pop_o) begin
			e1_q <= res;
		end
	end

	assign out_valid = (ofill_q != 2'd0);
	assign out_data  = e0_q;

	assign stat.out_free = (ofill_q != 2'd2);
	assign stat.imm      = imm;
	assign stat.peek     = is_peek;
	assign stat.fix_big  = fix_big;
	assign stat.div_done = div_done;
	assign stat.run_last = run_last;

endmodule

// ===== rtl/byte_ring_buffer_token_read.sv =====
// Top level of the byte ring buffer with counted, peek and token-delimited reads.
//
//  Channel   Direction  Handshake            Carries
//  items     in         items.valid/ready    mode, data_byte, count, token_byte,
//                                            peek_index, discard
//  results   out        results.valid/ready  read_byte, byte_position, last,
//                                            status, fill_level
//  cfg       in         cfg_we (no stall)    capacity_in_use
//
// An append item, and any item that yields a single status result, is done at
// intake and leaves the controller idle, so appends stream at one item per cycle
// while the result queue has room. A read run (remove count, remove until token,
// peek) starts with a registered memory read of its first byte and then emits its
// results, holding while the result queue is full. A peek first folds its start
// index by one subtraction of the capacity, then goes through the bit-serial remainder unit if still beyond it.
// Reset clears the pointers, the fill level and any open append run, and sets
// the capacity to 1024 (or the store depth if smaller); the byte store itself is
// not cleared. Results go through a two-entry queue, so a stalled consumer holds
// the run in place. New items are refused while a run or an index fold is under
// way and whenever the queue is full.
module byte_ring_buffer_token_read #(
	parameter int STORE_DEPTH = brtr_pkg::STORE_DEPTH_DEF,
	parameter int MAX_RUN     = brtr_pkg::MAX_RUN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [brtr_pkg::CAP_W-1:0] cfg_wdata,
	brtr_in_if.sink                    items,
	brtr_out_if.source                 results
);
	import brtr_pkg::*;

	// Commands flow from the controller to the datapath, status flows back.
	brtr_cmd_t  cmd;
	brtr_stat_t stat;

	// The controller owns the intake handshake; it only accepts an item while
	// idle and while the result queue has room for at least one more result.
	brtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the store, the pointers and the result queue, and
	// drives the result channel straight from the head of that queue.
	brtr_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_RUN     (MAX_RUN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (items.data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (results.data)
	);

endmodule
